[sv/rabc_pkg.sv]
package rabc_pkg;

    localparam int MAX_SEGMENTS = 64;
    localparam int MAX_WIDTH    = 2048;
    localparam int COUNT_BITS   = 24;

    localparam int SEG_W      = $clog2(MAX_SEGMENTS);
    localparam int SEGC_W     = SEG_W + 1;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int DIM_W      = 12;
    localparam int SEGCNT_W   = 7;
    localparam int PAIR_DEPTH = MAX_SEGMENTS * (MAX_SEGMENTS - 1) / 2;
    localparam int SLOT_W     = $clog2(PAIR_DEPTH);
    localparam int PADDR_W    = 4;
    localparam int PDATA_W    = 32;
    localparam int Q_DEPTH    = 2;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] MODE_PIX = 2'd0;
    localparam logic [1:0] MODE_QRY = 2'd1;
    localparam logic [1:0] MODE_CLR = 2'd2;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SEGCNT = 2'd2;

    localparam logic [1:0] CMD_PIX = 2'd0;
    localparam logic [1:0] CMD_QRY = 2'd1;
    localparam logic [1:0] CMD_CLR = 2'd2;
    localparam logic [1:0] CMD_ACK = 2'd3;

    typedef struct packed {
        logic [1:0]        kind;
        logic              err;
        logic              do_a;
        logic [SLOT_W-1:0] slot_a;
        logic              do_b;
        logic [SLOT_W-1:0] slot_b;
        logic [SEG_W-1:0]  seg;
    } cmd_t;

    typedef struct packed {
        logic [SEG_W-1:0]      seg;
        logic [COUNT_BITS-1:0] len;
        logic [SEG_W-1:0]      pos;
        logic                  has;
        logic                  err;
        logic                  last;
    } res_t;

    function automatic logic [SEGC_W-1:0] seg_limit(input logic [SEGCNT_W-1:0] sc);
        logic [SEGC_W-1:0] lim;
        lim = SEGC_W'(MAX_SEGMENTS);
        if (SEGC_W'(sc) > lim || sc > SEGCNT_W'(MAX_SEGMENTS))
            return lim;
        return SEGC_W'(sc);
    endfunction

    function automatic logic [SLOT_W-1:0] pair_slot(input logic [SEG_W-1:0] a,
                                                    input logic [SEG_W-1:0] b);
        logic [SEG_W-1:0]   lo;
        logic [SEG_W-1:0]   hi;
        logic [2*SEG_W-1:0] prod;
        hi   = (a < b) ? b : a;
        lo   = (a < b) ? a : b;
        prod = (2*SEG_W)'(hi) * (2*SEG_W)'(hi - 1'b1);
        return SLOT_W'((prod >> 1) + (2*SEG_W)'(lo));
    endfunction

endpackage

[sv/rabc_ram.sv]
module rabc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[sv/rabc_cmdq.sv]
module rabc_cmdq (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr,
    input  rabc_pkg::cmd_t wr_cmd,
    output logic          full,
    input  logic          rd,
    output rabc_pkg::cmd_t rd_cmd,
    output logic          empty
);
    import rabc_pkg::*;

    cmd_t            q_reg [Q_DEPTH];
    logic [Q_AW-1:0] wp_reg;
    logic [Q_AW-1:0] rp_reg;
    logic [Q_CW-1:0] cnt_reg;
    logic            do_wr;
    logic            do_rd;

    assign full   = (cnt_reg == Q_CW'(Q_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign do_wr  = wr && !full;
    assign do_rd  = rd && !empty;
    assign rd_cmd = q_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            q_reg[wp_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (do_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[sv/rabc_front.sv]
module rabc_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    output logic                          full,
    input  logic [1:0]                    mode,
    input  logic [rabc_pkg::SEG_W-1:0]    pixel_label,
    input  logic [rabc_pkg::SEG_W-1:0]    query_segment,
    input  logic [rabc_pkg::DIM_W-1:0]    image_width,
    input  logic [rabc_pkg::DIM_W-1:0]    image_height,
    input  logic [rabc_pkg::SEGCNT_W-1:0] segment_count,
    input  logic                          hold,
    output logic                          cmd_wr,
    output rabc_pkg::cmd_t                cmd,
    input  logic                          cmd_full
);
    import rabc_pkg::*;

    localparam logic F_IDLE = 1'b0;
    localparam logic F_PIX  = 1'b1;

    logic             state_reg, state_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [DIM_W-1:0] row_reg, row_next;
    logic [SEG_W-1:0] left_reg, left_next;
    logic [SEG_W-1:0] label_reg, label_next;
    logic [COL_W-1:0] pcol_reg, pcol_next;

    logic             accept;
    logic [DIM_W-1:0] w0, w_eff, h_eff;
    logic [COL_W-1:0] col_cur;
    logic [SEGC_W-1:0] n_eff;
    logic [SEG_W-1:0] above;
    logic             line_re, line_we;
    logic             lab_ok, left_ok, up_ok;

    assign full   = (state_reg == F_PIX) || cmd_full || hold;
    assign accept = push && !full;

    assign w0      = (image_width == '0) ? DIM_W'(1) : image_width;
    assign w_eff   = (w0 > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : w0;
    assign h_eff   = (image_height == '0) ? DIM_W'(1) : image_height;
    assign col_cur = (DIM_W'(col_reg) < w_eff) ? col_reg : COL_W'(w_eff - 1'b1);
    assign n_eff   = seg_limit(segment_count);

    assign line_re = accept && (mode == MODE_PIX);
    assign line_we = (state_reg == F_PIX) && !cmd_full;

    rabc_ram #(
        .WIDTH(SEG_W),
        .DEPTH(MAX_WIDTH)
    ) u_line (
        .clk  (clk),
        .we   (line_we),
        .waddr(pcol_reg),
        .wdata(label_reg),
        .re   (line_re),
        .raddr(col_cur),
        .rdata(above)
    );

    assign lab_ok  = SEGC_W'(label_reg) < n_eff;
    assign left_ok = SEGC_W'(left_reg) < n_eff;
    assign up_ok   = SEGC_W'(above) < n_eff;

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        left_next  = left_reg;
        label_next = label_reg;
        pcol_next  = pcol_reg;
        cmd_wr     = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        MODE_PIX:
                        begin
                            label_next = pixel_label;
                            pcol_next  = col_cur;
                            state_next = F_PIX;
                        end
                        MODE_QRY:
                        begin
                            cmd_wr = 1'b1;
                            if (SEGC_W'(query_segment) < n_eff)
                            begin
                                cmd.kind = CMD_QRY;
                                cmd.seg  = query_segment;
                            end
                            else
                            begin
                                cmd.kind = CMD_ACK;
                                cmd.err  = 1'b1;
                            end
                        end
                        MODE_CLR:
                        begin
                            cmd_wr    = 1'b1;
                            cmd.kind  = CMD_CLR;
                            col_next  = '0;
                            row_next  = '0;
                            left_next = '0;
                        end
                        default:
                        begin
                            cmd_wr   = 1'b1;
                            cmd.kind = CMD_ACK;
                        end
                    endcase
                end
            end
            F_PIX:
            begin
                cmd.kind   = CMD_PIX;
                cmd.err    = !lab_ok;
                cmd.do_a   = (pcol_reg != '0) && lab_ok && left_ok && (label_reg != left_reg);
                cmd.slot_a = pair_slot(left_reg, label_reg);
                cmd.do_b   = (row_reg != '0) && lab_ok && up_ok && (label_reg != above);
                cmd.slot_b = pair_slot(above, label_reg);
                if (!cmd_full)
                begin
                    cmd_wr     = 1'b1;
                    left_next  = label_reg;
                    state_next = F_IDLE;
                    if ((DIM_W'(pcol_reg) + 1'b1) >= w_eff)
                    begin
                        col_next = '0;
                        if (((DIM_W + 1)'(row_reg) + 1'b1) >= (DIM_W + 1)'(h_eff))
                        begin
                            row_next = '0;
                        end
                        else
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = pcol_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        label_reg <= label_next;
        pcol_reg  <= pcol_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            left_reg  <= left_next;
        end
    end

endmodule

[sv/rabc_back.sv]
module rabc_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rabc_pkg::cmd_t                cmd,
    input  logic                          cmd_empty,
    output logic                          cmd_rd,
    input  logic [rabc_pkg::SEGCNT_W-1:0] segment_count,
    output logic                          clearing,
    input  logic                          pop,
    output logic                          empty,
    output rabc_pkg::res_t                result
);
    import rabc_pkg::*;

    localparam logic [3:0] B_CLR  = 4'd0;
    localparam logic [3:0] B_IDLE = 4'd1;
    localparam logic [3:0] B_UA   = 4'd2;
    localparam logic [3:0] B_UAW  = 4'd3;
    localparam logic [3:0] B_UB   = 4'd4;
    localparam logic [3:0] B_UBW  = 4'd5;
    localparam logic [3:0] B_PACK = 4'd6;
    localparam logic [3:0] B_QRD  = 4'd7;
    localparam logic [3:0] B_QCHK = 4'd8;
    localparam logic [3:0] B_QEND = 4'd9;

    logic [3:0]            state_reg, state_next;
    logic [SLOT_W-1:0]     clr_reg, clr_next;
    cmd_t                  cur_reg, cur_next;
    logic [SEGC_W-1:0]     b_reg, b_next;
    logic [SEG_W-1:0]      k_reg, k_next;
    logic                  pend_valid_reg, pend_valid_next;
    res_t                  pend_reg, pend_next;

    res_t                  oq_reg [Q_DEPTH];
    logic [Q_AW-1:0]       wp_reg;
    logic [Q_AW-1:0]       rp_reg;
    logic [Q_CW-1:0]       cnt_reg;
    logic                  oq_full;
    logic                  res_wr;
    res_t                  res_in;
    logic                  res_rd;

    logic                  we, re;
    logic [SLOT_W-1:0]     waddr, raddr;
    logic [COUNT_BITS-1:0] wdata, rdata, inc;
    logic [SEGC_W-1:0]     n_eff;

    assign n_eff    = seg_limit(segment_count);
    assign inc      = (rdata == '1) ? rdata : rdata + 1'b1;
    assign clearing = (state_reg == B_CLR);
    assign oq_full  = (cnt_reg == Q_CW'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign res_rd   = pop && !empty;
    assign result   = oq_reg[rp_reg];

    rabc_ram #(
        .WIDTH(COUNT_BITS),
        .DEPTH(PAIR_DEPTH)
    ) u_counts (
        .clk  (clk),
        .we   (we),
        .waddr(waddr),
        .wdata(wdata),
        .re   (re),
        .raddr(raddr),
        .rdata(rdata)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        cur_next        = cur_reg;
        b_next          = b_reg;
        k_next          = k_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cmd_rd          = 1'b0;
        res_wr          = 1'b0;
        res_in          = '0;
        res_in.last     = 1'b1;
        we              = 1'b0;
        waddr           = '0;
        wdata           = '0;
        re              = 1'b0;
        raddr           = '0;
        unique case (state_reg)
            B_CLR:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == SLOT_W'(PAIR_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    unique case (cmd.kind)
                        CMD_PIX:
                        begin
                            cmd_rd     = 1'b1;
                            cur_next   = cmd;
                            state_next = B_UA;
                        end
                        CMD_QRY:
                        begin
                            cmd_rd          = 1'b1;
                            cur_next        = cmd;
                            b_next          = '0;
                            k_next          = '0;
                            pend_valid_next = 1'b0;
                            state_next      = B_QRD;
                        end
                        CMD_CLR:
                        begin
                            if (!oq_full)
                            begin
                                res_wr     = 1'b1;
                                cmd_rd     = 1'b1;
                                clr_next   = '0;
                                state_next = B_CLR;
                            end
                        end
                        default:
                        begin
                            if (!oq_full)
                            begin
                                res_wr     = 1'b1;
                                res_in.err = cmd.err;
                                cmd_rd     = 1'b1;
                            end
                        end
                    endcase
                end
            end
            B_UA:
            begin
                if (cur_reg.do_a)
                begin
                    re         = 1'b1;
                    raddr      = cur_reg.slot_a;
                    state_next = B_UAW;
                end
                else
                begin
                    state_next = B_UB;
                end
            end
            B_UAW:
            begin
                we         = 1'b1;
                waddr      = cur_reg.slot_a;
                wdata      = inc;
                state_next = B_UB;
            end
            B_UB:
            begin
                if (cur_reg.do_b)
                begin
                    re         = 1'b1;
                    raddr      = cur_reg.slot_b;
                    state_next = B_UBW;
                end
                else
                begin
                    state_next = B_PACK;
                end
            end
            B_UBW:
            begin
                we         = 1'b1;
                waddr      = cur_reg.slot_b;
                wdata      = inc;
                state_next = B_PACK;
            end
            B_PACK:
            begin
                if (!oq_full)
                begin
                    res_wr     = 1'b1;
                    res_in.err = cur_reg.err;
                    state_next = B_IDLE;
                end
            end
            B_QRD:
            begin
                if (b_reg >= n_eff)
                begin
                    state_next = B_QEND;
                end
                else if (b_reg[SEG_W-1:0] == cur_reg.seg)
                begin
                    b_next = b_reg + 1'b1;
                end
                else
                begin
                    re         = 1'b1;
                    raddr      = pair_slot(cur_reg.seg, b_reg[SEG_W-1:0]);
                    state_next = B_QCHK;
                end
            end
            B_QCHK:
            begin
                if (rdata == '0)
                begin
                    b_next     = b_reg + 1'b1;
                    state_next = B_QRD;
                end
                else if (!(pend_valid_reg && oq_full))
                begin
                    if (pend_valid_reg)
                    begin
                        res_wr = 1'b1;
                        res_in = pend_reg;
                    end
                    pend_valid_next = 1'b1;
                    pend_next.seg   = b_reg[SEG_W-1:0];
                    pend_next.len   = rdata;
                    pend_next.pos   = k_reg;
                    pend_next.has   = 1'b1;
                    pend_next.err   = 1'b0;
                    pend_next.last  = 1'b0;
                    k_next          = k_reg + 1'b1;
                    b_next          = b_reg + 1'b1;
                    state_next      = B_QRD;
                end
            end
            B_QEND:
            begin
                if (!oq_full)
                begin
                    res_wr = 1'b1;
                    if (pend_valid_reg)
                    begin
                        res_in      = pend_reg;
                        res_in.last = 1'b1;
                    end
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        k_reg    <= k_next;
        pend_reg <= pend_next;
        if (res_wr)
        begin
            oq_reg[wp_reg] <= res_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= B_CLR;
            clr_reg        <= '0;
            b_reg          <= '0;
            pend_valid_reg <= 1'b0;
            wp_reg         <= '0;
            rp_reg         <= '0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            b_reg          <= b_next;
            pend_valid_reg <= pend_valid_next;
            if (res_wr)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (res_rd)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            if (res_wr && !res_rd)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (res_rd && !res_wr)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

[sv/region_adjacency_border_counter_unit.sv]
// Region adjacency border counter.
// Input queue: present mode/pixel_label/query_segment with push; a word is
// taken at a clock edge where push is high and full is low. Mode pixel sends
// the next label of the map in raster order, mode query asks for a segment's
// neighbour list, mode clear zeroes all border counts and restarts the raster.
// Result queue: while empty is low the oldest result is on the result ports;
// pop takes it. Every pixel, clear or unused-mode word gives one result with
// last set; a query gives one result per neighbour in rising index order,
// last set on the final one, or a single result with has_neighbour low.
// A pixel passes the front's line store read and hand-off, then back
// states UA and UB, each followed by a write state if its pair is counted,
// then PACK. A counted pair is a read-modify-write of the count memory
// (one read, one write port); a query reads each active segment's pair count.
// After reset and each clear word all 2016 count entries are swept to
// zero, one per cycle, with full held high; the APB port stays usable.
// When pop is held low the result queue fills, the back end stalls, then
// the command queue fills and full rises; nothing is lost.
module region_adjacency_border_counter_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rabc_pkg::PADDR_W-1:0]      paddr,
    input  logic [rabc_pkg::PDATA_W-1:0]      pwdata,
    output logic [rabc_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        mode,
    input  logic [rabc_pkg::SEG_W-1:0]        pixel_label,
    input  logic [rabc_pkg::SEG_W-1:0]        query_segment,
    output logic                              empty,
    input  logic                              pop,
    output logic [rabc_pkg::SEG_W-1:0]        neighbour_segment,
    output logic [rabc_pkg::COUNT_BITS-1:0]   border_length,
    output logic [rabc_pkg::SEG_W-1:0]        neighbour_position,
    output logic                              has_neighbour,
    output logic                              label_error,
    output logic                              last
);
    import rabc_pkg::*;

    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [SEGCNT_W-1:0] segcnt_reg;
    logic [1:0]          reg_idx;
    logic                cfg_wr;

    logic  cmd_wr, cmd_full, cmd_rd, cmd_empty, clearing;
    cmd_t  cmd_in, cmd_out;
    res_t  result;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb
    begin
        unique case (reg_idx)
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_SEGCNT: prdata = PDATA_W'(segcnt_reg);
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(640);
            height_reg <= DIM_W'(480);
            segcnt_reg <= SEGCNT_W'(64);
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_SEGCNT: segcnt_reg <= pwdata[SEGCNT_W-1:0];
                default:    ;
            endcase
        end
    end

    rabc_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .mode         (mode),
        .pixel_label  (pixel_label),
        .query_segment(query_segment),
        .image_width  (width_reg),
        .image_height (height_reg),
        .segment_count(segcnt_reg),
        .hold         (clearing),
        .cmd_wr       (cmd_wr),
        .cmd          (cmd_in),
        .cmd_full     (cmd_full)
    );

    rabc_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (cmd_wr),
        .wr_cmd(cmd_in),
        .full  (cmd_full),
        .rd    (cmd_rd),
        .rd_cmd(cmd_out),
        .empty (cmd_empty)
    );

    rabc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd_out),
        .cmd_empty    (cmd_empty),
        .cmd_rd       (cmd_rd),
        .segment_count(segcnt_reg),
        .clearing     (clearing),
        .pop          (pop),
        .empty        (empty),
        .result       (result)
    );

    assign neighbour_segment  = result.seg;
    assign border_length      = result.len;
    assign neighbour_position = result.pos;
    assign has_neighbour      = result.has;
    assign label_error        = result.err;
    assign last               = result.last;

endmodule
